// ----- rtl/usb_id_line_filter_unit_defines.svh -----
// Assertion macros for the USB id line filter unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef USB_ID_LINE_FILTER_UNIT_DEFINES_SVH
`define USB_ID_LINE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ULF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ULF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ulf_pkg.sv -----
// Shared types, constants and scan functions of the USB id line filter.
// No dependencies; used by every module of the block.
package ulf_pkg;

  localparam int unsigned CfgRegs   = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned ResultW   = 35;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTRY_0 = 2'd0,
    REG_ENTRY_1 = 2'd1,
    REG_ENTRY_2 = 2'd2,
    REG_ENTRY_3 = 2'd3
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] TABLE_RESET [CfgRegs] = '{
    32'h16D0_27DB, 32'h1781_0C9F, 32'h1A86_7523, 32'h1A86_7523
  };

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UP_D  = 8'h44;
  localparam logic [7:0] CHAR_UP_I  = 8'h49;
  localparam logic [7:0] CHAR_UP_P  = 8'h50;
  localparam logic [7:0] CHAR_UP_V  = 8'h56;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;

  localparam logic [2:0] KEY_LEN = 3'd4;

  typedef enum logic [2:0] {
    PH_BLANKS = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } num_phase_e;

  typedef struct packed {
    logic [2:0]  key_progress;
    logic        key_found;
    num_phase_e  phase;
    logic [15:0] acc;
    logic        negative;
  } scan_t;

  localparam scan_t SCAN_CLEAR = '{
    key_progress: 3'd0, key_found: 1'b0, phase: PH_BLANKS, acc: 16'h0000, negative: 1'b0
  };

  // One id pair handed from the parser to the matcher
  typedef struct packed {
    logic [15:0] vid;
    logic [15:0] pid;
  } req_t;

  // Result word, blocked in the lowest bit
  typedef struct packed {
    logic [15:0] product_id;
    logic [15:0] vendor_id;
    logic [1:0]  entry_index;
    logic        blocked;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

  function automatic logic [7:0] key_tail(logic [2:0] progress);
    logic [7:0] r;
    unique case (progress)
      3'd1:    r = CHAR_UP_I;
      3'd2:    r = CHAR_UP_D;
      3'd3:    r = CHAR_COLON;
      default: r = CHAR_NUL;
    endcase
    return r;
  endfunction

  function automatic scan_t number_step(scan_t s, logic [7:0] c);
    scan_t      n;
    logic [4:0] h;
    n = s;
    h = hex_digit(c);
    priority if (s.phase == PH_BLANKS && is_blank(c)) begin
      n = s;
    end else if (s.phase == PH_BLANKS && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      n.negative = (c == CHAR_MINUS);
      n.phase    = PH_SIGN;
    end else if (s.phase == PH_BLANKS || s.phase == PH_SIGN) begin
      priority if (c == CHAR_ZERO) begin
        n.phase = PH_ZERO;
      end else if (h[4]) begin
        n.acc   = {12'h000, h[3:0]};
        n.phase = PH_DIGITS;
      end else begin
        n.phase = PH_DONE;
      end
    end else if (s.phase == PH_ZERO) begin
      priority if (c == CHAR_LO_X || c == CHAR_UP_X) begin
        n.phase = PH_PREFIX;
      end else if (h[4]) begin
        n.acc   = {12'h000, h[3:0]};
        n.phase = PH_DIGITS;
      end else begin
        n.phase = PH_DONE;
      end
    end else if (s.phase == PH_PREFIX || s.phase == PH_DIGITS) begin
      if (h[4]) begin
        n.acc   = {s.acc[11:0], h[3:0]};
        n.phase = PH_DIGITS;
      end else begin
        n.phase = PH_DONE;
      end
    end else begin
      n.phase = PH_DONE;
    end
    return n;
  endfunction

  // Key letters are all distinct, so a mismatch restarts the match.
  function automatic scan_t scan_step(scan_t s, logic [7:0] c, logic [7:0] first);
    scan_t n;
    n = s;
    if (s.key_found) begin
      n = number_step(s, c);
    end else if (s.key_progress != 3'd0 && s.key_progress < KEY_LEN &&
                 c == key_tail(s.key_progress)) begin
      n.key_progress = s.key_progress + 3'd1;
      n.key_found    = (s.key_progress == KEY_LEN - 3'd1);
    end else begin
      n.key_progress = (c == first) ? 3'd1 : 3'd0;
    end
    return n;
  endfunction

  function automatic logic [15:0] scan_value(scan_t s);
    return s.negative ? (16'h0000 - s.acc) : s.acc;
  endfunction

endpackage

// ----- rtl/usb_id_line_filter_unit.sv -----
// Throughput: one text byte per cycle unless the request queue is full.
// At most one result per line, set by the parser step, goes through the two-entry queue.
// The output register drains one result per cycle while the receiver is ready.
// Reset (async, active low) clears line state, queue and output valid, and loads the
// table with its default entries. No clearing pass; the block takes bytes right after reset.
`include "usb_id_line_filter_unit_defines.svh"

module usb_id_line_filter_unit #(
  parameter int unsigned LINE_LIMIT    = 128,
  parameter int unsigned TABLE_ENTRIES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ulf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ulf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // text byte stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ulf_pkg::InDataW-1:0]   s_axis_tdata_i,  // [7:0] rx_byte
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] blocked, [2:1] entry_index, [18:3] vendor_id, [34:19] product_id, [39:35] zero
  output logic [ulf_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  logic               push, pop;
  ulf_pkg::req_t      push_data, head;
  ulf_pkg::q_status_t q_status;
  ulf_pkg::result_t   result;

  // Front: take bytes, scan keys and numbers, push an id pair at line end.
  ulf_front #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Queue: decouple the parser from a stalled result consumer.
  ulf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back: match the pair against the table and hold the result.
  ulf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (ulf_pkg::cfg_reg_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (!q_status.empty),
    .req_i       (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (result)
  );

  assign m_axis_tdata_o = {(ulf_pkg::OutDataW - ulf_pkg::ResultW)'(0), result};

  // A pushed request is waiting in the queue on the next cycle.
  `ULF_ASSERT_NEXT(a_push_lands, push, !q_status.empty, "pushed request missing from queue")
  // A new result only follows a request taken from the queue.
  `ULF_ASSERT_IMPL(a_result_from_pop, $rose(m_axis_tvalid_o), $past(pop), "result without request")
  // An unblocked result reports entry zero.
  `ULF_ASSERT_IMPL(a_idx_zero, m_axis_tvalid_o && !result.blocked, result.entry_index == 2'd0,
                   "entry index set on an unblocked result")

endmodule

// ----- rtl/ulf_front.sv -----
// Front end: accepts text bytes, tracks the line and scans for both keys.
// Depends on ulf_pkg; pushes one id pair per qualifying line end.
module ulf_front #(
  parameter int unsigned LINE_LIMIT = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_valid_i,
  output logic                         byte_ready_o,
  input  logic [ulf_pkg::InDataW-1:0]  byte_i,
  input  ulf_pkg::q_status_t           q_status_i,
  output logic                         push_o,
  output ulf_pkg::req_t                push_data_o
);

  localparam int unsigned CountW = $clog2(LINE_LIMIT);

  logic [CountW-1:0] count_q, count_d;
  logic              hidden_q, hidden_d;
  ulf_pkg::scan_t    vid_q, vid_d, pid_q, pid_d;
  logic              take, line_end;

  assign byte_ready_o = !q_status_i.full;
  assign take         = byte_valid_i && byte_ready_o;
  assign line_end     = (byte_i == ulf_pkg::CHAR_LF) || (byte_i == ulf_pkg::CHAR_CR);

  assign push_o            = take && line_end && vid_q.key_found && pid_q.key_found;
  assign push_data_o.vid   = ulf_pkg::scan_value(vid_q);
  assign push_data_o.pid   = ulf_pkg::scan_value(pid_q);

  always_comb begin
    count_d  = count_q;
    hidden_d = hidden_q;
    vid_d    = vid_q;
    pid_d    = pid_q;
    if (take) begin
      priority if (line_end) begin
        count_d  = '0;
        hidden_d = 1'b0;
        vid_d    = ulf_pkg::SCAN_CLEAR;
        pid_d    = ulf_pkg::SCAN_CLEAR;
      end else if (hidden_q || count_q >= CountW'(LINE_LIMIT - 1)) begin
        // drop bytes past the counted length or after a NUL
        count_d = count_q;
      end else begin
        count_d = count_q + CountW'(1);
        if (byte_i == ulf_pkg::CHAR_NUL) begin
          hidden_d = 1'b1;
        end else begin
          vid_d = ulf_pkg::scan_step(vid_q, byte_i, ulf_pkg::CHAR_UP_V);
          pid_d = ulf_pkg::scan_step(pid_q, byte_i, ulf_pkg::CHAR_UP_P);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      hidden_q <= 1'b0;
      vid_q    <= ulf_pkg::SCAN_CLEAR;
      pid_q    <= ulf_pkg::SCAN_CLEAR;
    end else begin
      count_q  <= count_d;
      hidden_q <= hidden_d;
      vid_q    <= vid_d;
      pid_q    <= pid_d;
    end
  end

endmodule

// ----- rtl/ulf_queue.sv -----
// Two-entry request queue between parser and matcher.
// Depends on ulf_pkg for the request and status types.
module ulf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ulf_pkg::req_t      push_data_i,
  input  logic               pop_i,
  output ulf_pkg::req_t      head_o,
  output ulf_pkg::q_status_t status_o
);

  ulf_pkg::req_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

  always_comb begin
    count_d = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/ulf_back.sv -----
// Back end: holds the blocked-device table, matches queued id pairs and
// registers the result. Depends on ulf_pkg.
module ulf_back #(
  parameter int unsigned TABLE_ENTRIES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  ulf_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [ulf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          req_valid_i,
  input  ulf_pkg::req_t                 req_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ulf_pkg::result_t              out_data_o
);

  logic [ulf_pkg::CfgDataW-1:0] table_q [ulf_pkg::CfgRegs];
  logic                         out_valid_q;
  ulf_pkg::result_t             out_data_q;
  logic [ulf_pkg::CfgDataW-1:0] pair;
  logic                         hit;
  logic [1:0]                   hit_idx;

  assign pair        = {req_i.vid, req_i.pid};
  assign pop_o       = req_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Walk from the top so the lowest matching entry wins; slots past the
  // writable registers read as zero.
  always_comb begin
    hit     = 1'b0;
    hit_idx = 2'd0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (i < ulf_pkg::CfgRegs) begin
        if (table_q[2'(i)] == pair) begin
          hit     = 1'b1;
          hit_idx = 2'(i);
        end
      end else if (pair == '0) begin
        hit     = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ulf_pkg::CfgRegs; i++) begin
        table_q[i] <= ulf_pkg::TABLE_RESET[i];
      end
    end else if (cfg_we_i) begin
      table_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q.blocked     <= hit;
      out_data_q.entry_index <= hit_idx;
      out_data_q.vendor_id   <= req_i.vid;
      out_data_q.product_id  <= req_i.pid;
    end
  end

endmodule

// ----- tb/tb_usb_id_line_filter_unit.sv -----
// Self-checking bench for the USB id line filter: streams text lines, predicts each
// verdict from its own line parser and compares every result field by field.
// Depends on ulf_pkg (types, character codes, default table) and the unit's RTL.
module tb_usb_id_line_filter_unit;

  localparam int unsigned LINE_LIMIT    = 128;
  localparam int unsigned TABLE_ENTRIES = 4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;      // receiver hold-off to back up the queue
  localparam int unsigned LIMIT_TIME    = 2_000_000;

  localparam logic [7:0] TB_NINE = "9";
  localparam logic [7:0] TB_LO_A = "a";
  localparam logic [7:0] TB_LO_F = "f";
  localparam logic [7:0] TB_UP_A = "A";
  localparam logic [7:0] TB_UP_F = "F";

  // Per-key scan state of the predictor
  typedef struct {
    logic [2:0]          matched;
    bit                  found;
    ulf_pkg::num_phase_e phase;
    logic [15:0]         value;
    bit                  minus;
  } key_scan_t;

  // Line parser and verdict store
  class verdict_tracker;
    logic [31:0]      blocklist [ulf_pkg::CfgRegs];
    int unsigned      line_len;
    bit               line_masked;
    key_scan_t        vid_scan;
    key_scan_t        pid_scan;
    ulf_pkg::result_t pending_verdicts [$];
    int unsigned      errors;
    int unsigned      verdicts_seen;
    int unsigned      hits_seen;
    int unsigned      counted_bytes;
    int unsigned      lines_seen;

    function new();
      for (int i = 0; i < ulf_pkg::CfgRegs; i++) blocklist[i] = ulf_pkg::TABLE_RESET[i];
      clear_line();
    endfunction

    function void clear_line();
      line_len    = 0;
      line_masked = 0;
      vid_scan    = '{matched: 3'd0, found: 0, phase: ulf_pkg::PH_BLANKS, value: 16'h0000,
                      minus: 0};
      pid_scan    = vid_scan;
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= ulf_pkg::CHAR_ZERO && c <= TB_NINE) return int'(c - ulf_pkg::CHAR_ZERO);
      if (c >= TB_LO_A && c <= TB_LO_F) return int'(c - TB_LO_A) + 10;
      if (c >= TB_UP_A && c <= TB_UP_F) return int'(c - TB_UP_A) + 10;
      return -1;
    endfunction

    // One byte of a %hx scan after the key
    function key_scan_t number_next(key_scan_t s, logic [7:0] c);
      key_scan_t n;
      int        d;
      bit        blank;
      n     = s;
      d     = hex_of(c);
      blank = (c == ulf_pkg::CHAR_SPACE) || (c == ulf_pkg::CHAR_TAB) ||
              (c == ulf_pkg::CHAR_VT) || (c == ulf_pkg::CHAR_FF);
      case (s.phase)
        ulf_pkg::PH_BLANKS, ulf_pkg::PH_SIGN: begin
          if (s.phase == ulf_pkg::PH_BLANKS && blank) return n;
          if (s.phase == ulf_pkg::PH_BLANKS &&
              (c == ulf_pkg::CHAR_PLUS || c == ulf_pkg::CHAR_MINUS)) begin
            n.minus = (c == ulf_pkg::CHAR_MINUS);
            n.phase = ulf_pkg::PH_SIGN;
          end else if (c == ulf_pkg::CHAR_ZERO) begin
            n.phase = ulf_pkg::PH_ZERO;
          end else if (d >= 0) begin
            n.value = 16'(d);
            n.phase = ulf_pkg::PH_DIGITS;
          end else begin
            n.phase = ulf_pkg::PH_DONE;
          end
        end
        ulf_pkg::PH_ZERO: begin
          if (c == ulf_pkg::CHAR_LO_X || c == ulf_pkg::CHAR_UP_X) begin
            n.phase = ulf_pkg::PH_PREFIX;
          end else if (d >= 0) begin
            n.value = 16'(d);
            n.phase = ulf_pkg::PH_DIGITS;
          end else begin
            n.phase = ulf_pkg::PH_DONE;
          end
        end
        ulf_pkg::PH_PREFIX, ulf_pkg::PH_DIGITS: begin
          if (d >= 0) begin
            n.value = {s.value[11:0], 4'(d)};
            n.phase = ulf_pkg::PH_DIGITS;
          end else begin
            n.phase = ulf_pkg::PH_DONE;
          end
        end
        default: n.phase = ulf_pkg::PH_DONE;
      endcase
      return n;
    endfunction

    // Key search, then number scan once the key is complete
    function key_scan_t key_next(key_scan_t s, logic [7:0] c, logic [7:0] first);
      key_scan_t  n;
      logic [7:0] tail;
      n = s;
      if (s.found) return number_next(s, c);
      case (s.matched)
        3'd1:    tail = ulf_pkg::CHAR_UP_I;
        3'd2:    tail = ulf_pkg::CHAR_UP_D;
        3'd3:    tail = ulf_pkg::CHAR_COLON;
        default: tail = ulf_pkg::CHAR_NUL;
      endcase
      if (s.matched != 3'd0 && s.matched < ulf_pkg::KEY_LEN && c == tail) begin
        n.matched = s.matched + 3'd1;
        n.found   = (n.matched == ulf_pkg::KEY_LEN);
      end else begin
        n.matched = (c == first) ? 3'd1 : 3'd0;
      end
      return n;
    endfunction

    // Note one accepted text byte; a line end holding both keys queues a verdict
    function void note_byte(logic [7:0] c);
      ulf_pkg::result_t v;
      logic [15:0]      vid;
      logic [15:0]      pid;
      if (c == ulf_pkg::CHAR_LF || c == ulf_pkg::CHAR_CR) begin
        counted_bytes++;
        lines_seen++;
        if (vid_scan.found && pid_scan.found) begin
          vid = vid_scan.minus ? 16'h0000 - vid_scan.value : vid_scan.value;
          pid = pid_scan.minus ? 16'h0000 - pid_scan.value : pid_scan.value;
          v   = '{product_id: pid, vendor_id: vid, entry_index: 2'd0, blocked: 1'b0};
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!v.blocked && blocklist[i] == {vid, pid}) begin
              v.blocked     = 1'b1;
              v.entry_index = 2'(i);
            end
          end
          pending_verdicts.push_back(v);
        end
        clear_line();
        return;
      end
      if (line_masked || line_len >= LINE_LIMIT - 1) return;
      line_len++;
      counted_bytes++;
      if (c == ulf_pkg::CHAR_NUL) begin
        line_masked = 1;
        return;
      end
      vid_scan = key_next(vid_scan, c, ulf_pkg::CHAR_UP_V);
      pid_scan = key_next(pid_scan, c, ulf_pkg::CHAR_UP_P);
    endfunction

    function void check_verdict(logic [ulf_pkg::OutDataW-1:0] data);
      ulf_pkg::result_t got;
      ulf_pkg::result_t want;
      got = ulf_pkg::result_t'(data[ulf_pkg::ResultW-1:0]);
      if (pending_verdicts.size() == 0) begin
        $error("result %h with no verdict pending", data);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts_seen++;
      if (want.blocked) hits_seen++;
      if (got.blocked !== want.blocked) begin
        $error("blocked: expected %0h actual %0h", want.blocked, got.blocked);
        errors++;
      end
      if (got.entry_index !== want.entry_index) begin
        $error("entry_index: expected %0h actual %0h", want.entry_index, got.entry_index);
        errors++;
      end
      if (got.vendor_id !== want.vendor_id) begin
        $error("vendor_id: expected %h actual %h", want.vendor_id, got.vendor_id);
        errors++;
      end
      if (got.product_id !== want.product_id) begin
        $error("product_id: expected %h actual %h", want.product_id, got.product_id);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [ulf_pkg::CfgIdxW-1:0]  cfg_idx_i       = ulf_pkg::REG_ENTRY_0;
  logic [ulf_pkg::CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [ulf_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [ulf_pkg::OutDataW-1:0] m_axis_tdata_o;

  verdict_tracker sb;
  logic [7:0]     line_q [$];       // bytes of the line being built
  bit             gaps_on;          // random idling on both sides
  int unsigned    hold_cycles;      // pending long hold-off request for the receiver
  int unsigned    table_loads;

  usb_id_line_filter_unit #(
    .LINE_LIMIT   (LINE_LIMIT),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [7:0] rx_byte
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)    // [0] blocked, [2:1] entry_index,
                                        // [18:3] vendor_id, [34:19] product_id
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check every accepted result at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_verdict(m_axis_tdata_o);
  end

  // Receiver: drive ready at the falling edge; a long hold-off request is
  // counted out here while the sender keeps offering bytes.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk_i);
        hold_cycles = 0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Hard stop in case a request never completes.
  initial begin
    #(LIMIT_TIME);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one byte and hold it until the request is taken. Enter and leave at
  // a falling edge; valid stays high between back-to-back bytes.
  task automatic send_byte(logic [7:0] c);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(c);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic end_line(logic [7:0] term);
    line_q.push_back(term);
    send_line();
  endtask

  // Drop valid, wait out every pending verdict, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all four table entries; call only while the block is idle.
  task automatic load_blocklist(logic [31:0] v [ulf_pkg::CfgRegs]);
    ulf_pkg::cfg_reg_e r;
    int                i;
    r = ulf_pkg::REG_ENTRY_0;
    for (i = 0; i < ulf_pkg::CfgRegs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= r;
      cfg_wdata_i <= v[i];
      @(posedge clk_i);
      sb.blocklist[i] = v[i];
      @(negedge clk_i);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
    table_loads++;
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d, bit upper);
    if (d < 4'd10) return ulf_pkg::CHAR_ZERO + 8'(d);
    return (upper ? TB_UP_A : TB_LO_A) + 8'(d) - 8'd10;
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       line_q.push_back(ulf_pkg::CHAR_SPACE);
        1:       line_q.push_back(ulf_pkg::CHAR_TAB);
        2:       line_q.push_back(ulf_pkg::CHAR_VT);
        default: line_q.push_back(ulf_pkg::CHAR_FF);
      endcase
    end
  endfunction

  // Print a 16-bit id in one of the many spellings a %hx scan accepts.
  function automatic void add_hex(logic [15:0] v);
    logic [15:0] mag;
    int          need;
    int          ndig;
    mag = v;
    case ($urandom_range(0, 7))
      0, 1: begin
        line_q.push_back(ulf_pkg::CHAR_MINUS);
        mag = 16'h0000 - v;
      end
      2:       line_q.push_back(ulf_pkg::CHAR_PLUS);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      1:       add_text("0x");
      2:       add_text("0X");
      default: ;
    endcase
    // extra high digits fall off the 16-bit value
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) line_q.push_back(hex_char(4'($urandom), $urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 1)) line_q.push_back(ulf_pkg::CHAR_ZERO);
    need = (mag[15:12] != 0) ? 4 : (mag[11:8] != 0) ? 3 : (mag[7:4] != 0) ? 2 : 1;
    ndig = $urandom_range(need, 4);
    for (int k = ndig - 1; k >= 0; k--) begin
      line_q.push_back(hex_char(mag[k*4 +: 4], $urandom_range(0, 1)));
    end
  endfunction

  function automatic void add_separator();
    case ($urandom_range(0, 3))
      0:       add_text(",");
      1:       add_text(";");
      2:       add_text(" / ");
      default: line_q.push_back(ulf_pkg::CHAR_SPACE);
    endcase
  endfunction

  function automatic void add_key_value(bit vid_key, logic [15:0] v);
    add_text(vid_key ? "VID:" : "PID:");
    add_blanks();
    add_hex(v);
  endfunction

  // Build one random line: mostly well-formed id reports, some with one key,
  // hidden tail or overflow, and some raw noise.
  function automatic void gen_random_line();
    logic [31:0] pair;
    int          kind;
    int          where;
    bit          vid_first;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(33, 126)));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: pair = sb.blocklist[$urandom_range(0, ulf_pkg::CfgRegs - 1)];
        6:       pair = {sb.blocklist[$urandom_range(0, ulf_pkg::CfgRegs - 1)][31:16],
                         16'($urandom)};
        default: pair = $urandom;
      endcase
      vid_first = ($urandom_range(0, 3) != 0);
      add_key_value(vid_first, vid_first ? pair[31:16] : pair[15:0]);
      add_separator();
      add_key_value(!vid_first, vid_first ? pair[15:0] : pair[31:16]);
      if ($urandom_range(0, 4) == 0) add_text(" ok");
      if ($urandom_range(0, 19) == 0) begin
        where = $urandom_range(0, line_q.size());
        line_q.insert(where, ulf_pkg::CHAR_NUL);
      end
      if ($urandom_range(0, 39) == 0) begin
        where = $urandom_range(0, line_q.size());
        repeat ($urandom_range(100, 130)) line_q.insert(where, 8'($urandom_range(103, 122)));
      end
      if ($urandom_range(0, 14) == 0) line_q.delete($urandom_range(0, line_q.size() - 1));
    end else if (kind < 86) begin
      vid_first = $urandom_range(0, 1);
      add_key_value(vid_first, 16'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        add_separator();
        case ($urandom_range(0, 2))
          0:       add_text(vid_first ? "PI:" : "VD:");
          1:       add_text(vid_first ? "pid:" : "vid:");
          default: add_text(vid_first ? "PID " : "VID ");
        endcase
        add_hex(16'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 4))
      0, 1:    line_q.push_back(ulf_pkg::CHAR_LF);
      2, 3:    line_q.push_back(ulf_pkg::CHAR_CR);
      default: begin
        line_q.push_back(ulf_pkg::CHAR_CR);
        line_q.push_back(ulf_pkg::CHAR_LF);
      end
    endcase
  endfunction

  // Stream random lines until about quota bytes have counted.
  task automatic run_random(int unsigned quota);
    int unsigned start;
    start = sb.counted_bytes;
    while (sb.counted_bytes - start < quota) begin
      gen_random_line();
      send_line();
    end
  endtask

  task automatic run_directed();
    add_text("VID:16d0 PID:27db");                 // hit on entry zero
    end_line(ulf_pkg::CHAR_LF);
    add_text("PID:0x7523 VID:0X1A86");             // entries two and three equal: lowest wins
    end_line(ulf_pkg::CHAR_CR);
    add_text("VID:1781,PID:0C9F");
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:ffff PID:0000");                 // field extremes, no hit
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:-1 PID:+0x0");                   // negative sign wraps to 16 bits
    end_line(ulf_pkg::CHAR_CR);
    add_text("VID:");                              // blanks before the sign, then no digits
    line_q.push_back(ulf_pkg::CHAR_SPACE);
    line_q.push_back(ulf_pkg::CHAR_TAB);
    line_q.push_back(ulf_pkg::CHAR_VT);
    line_q.push_back(ulf_pkg::CHAR_FF);
    add_text("- 5 PID:+");
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:0xg PID:0Xz");                   // lone prefix reads as zero
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:123456789abcdef PID:DEADBEEF0"); // long numbers keep the low digits
    end_line(ulf_pkg::CHAR_CR);
    add_text("VID:16d0 only");                     // missing key: no result
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:16d0 ");                         // NUL hides the second key
    line_q.push_back(ulf_pkg::CHAR_NUL);
    add_text("PID:27db");
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:1 ");                            // overflow cuts the number after "27"
    repeat (115) line_q.push_back("z");
    add_text("PID:27db");
    end_line(ulf_pkg::CHAR_CR);
    line_q.push_back(8'hFF);                       // extreme byte codes in the text
    line_q.push_back(8'h80);
    line_q.push_back(8'h7F);
    add_text("VID:0 PID:0");
    end_line(ulf_pkg::CHAR_LF);
    add_text("VVID:: PPID:1");                     // key restart on a repeated letter
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:0x16D0PID:27DB");                // number ends on the next key letter
    line_q.push_back(ulf_pkg::CHAR_CR);
    end_line(ulf_pkg::CHAR_LF);                    // empty line after CR: no result
  endtask

  initial begin
    logic [31:0] vals [ulf_pkg::CfgRegs];
    sb          = new();
    gaps_on     = 1;
    hold_cycles = 0;
    table_loads = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default table straight out of reset.
    run_directed();
    run_random(150);
    drain();

    // Extremes of the table entries.
    vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000};
    load_blocklist(vals);
    add_text("VID:0 PID:-0");
    end_line(ulf_pkg::CHAR_LF);
    add_text("VID:-1 PID:ffff");
    end_line(ulf_pkg::CHAR_LF);
    run_random(170);
    drain();

    // Duplicate entries; hold the receiver off so the block backs up and
    // stalls its input while bytes keep coming.
    vals[0] = $urandom;
    vals[1] = $urandom;
    vals[2] = $urandom;
    vals[3] = vals[1];
    load_blocklist(vals);
    hold_cycles = LONG_HOLD;
    repeat (8) begin
      add_key_value(1, vals[3][31:16]);
      add_separator();
      add_key_value(0, vals[3][15:0]);
      end_line(ulf_pkg::CHAR_LF);
    end
    run_random(160);
    drain();

    // Fully random table.
    foreach (vals[i]) vals[i] = $urandom;
    load_blocklist(vals);
    run_random(160);
    drain();

    // Back to the default table, no idling for the rest of the run.
    foreach (vals[i]) vals[i] = ulf_pkg::TABLE_RESET[i];
    load_blocklist(vals);
    gaps_on = 0;
    run_random(160);
    drain();

    $display("Covered %0d lines (%0d counted bytes) over %0d table loads.",
             sb.lines_seen, sb.counted_bytes, table_loads);
    $display("Checked %0d verdicts, %0d of them blocked; %0d still pending.",
             sb.verdicts_seen, sb.hits_seen, sb.pending_verdicts.size());
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ulf_pkg.sv
rtl/ulf_front.sv
rtl/ulf_queue.sv
rtl/ulf_back.sv
rtl/usb_id_line_filter_unit.sv
tb/tb_usb_id_line_filter_unit.sv
